// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk; PRA_ASSERT is disabled during active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define PRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Types, widths and constants shared by the point rotation pipeline.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int COORD_W          = 32;  // signed Q16.16 coordinates
    localparam int ANGLE_W          = 32;  // binary angle, full turn = 2^32
    localparam int CS_W             = 32;  // cordic x/y datapath, Q2.30
    localparam int FRAC_W           = 30;  // fraction bits of cos and sin
    localparam int MAX_STEPS        = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    // limit gain of the cordic, 0.6072529350 in Q2.30
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // atan(2^-i) in binary angle units, rounded to nearest
    localparam logic signed [ANGLE_W-1:0] ARC_TABLE [MAX_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1,         32'sd1,         32'sd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic signed [ANGLE_W-1:0] turn_angle;
    } pra_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic                      saturated;
    } pra_out_t;

endpackage

// ===== hdl/pra_cordic.sv =====
// ----------------------------------------------------------------------------
// pra_cordic
// Pipelined rotation-mode cordic, one iteration per stage, giving cos and
// sin in Q2.30 with a side word carried alongside each angle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pra_cordic #(
    parameter int STEPS  = pra_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic        [pra_pkg::ANGLE_W-1:0] in_angle,
    input  logic        [SIDE_W-1:0]           in_side,
    output logic                               out_valid,
    output logic signed [pra_pkg::CS_W-1:0]    out_cos,
    output logic signed [pra_pkg::CS_W-1:0]    out_sin,
    output logic        [SIDE_W-1:0]           out_side
);

    localparam int CW = pra_pkg::CS_W;
    localparam int AW = pra_pkg::ANGLE_W;
    localparam logic signed [CW-1:0] CS_LIM =
        CW'((1 << pra_pkg::FRAC_W) + (1 << (pra_pkg::FRAC_W - 6)));

    logic signed [CW-1:0]     x_reg    [0:STEPS];
    logic signed [CW-1:0]     y_reg    [0:STEPS];
    logic signed [AW-1:0]     z_reg    [0:STEPS];
    logic                     flip_reg [0:STEPS];
    logic        [SIDE_W-1:0] side_reg [0:STEPS];
    logic                     v_reg    [0:STEPS];

    logic signed [CW-1:0] x_next [1:STEPS];
    logic signed [CW-1:0] y_next [1:STEPS];
    logic signed [AW-1:0] z_next [1:STEPS];

    logic                 out_valid_reg;
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    logic [SIDE_W-1:0]    out_side_reg;

    logic                 flip_in;
    logic signed [AW-1:0] z_in;

    // fold into a quarter turn either way; half a turn is a flip of the top bit
    always_comb begin
        flip_in = in_angle[AW-1] ^ in_angle[AW-2];
        z_in    = signed'({in_angle[AW-1] ^ flip_in, in_angle[AW-2:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= pra_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
            flip_reg[0] <= flip_in;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        always_comb begin
            if (!z_reg[k][AW-1]) begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - pra_pkg::ARC_TABLE[k];
            end else begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + pra_pkg::ARC_TABLE[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]    <= x_next[k+1];
                y_reg[k+1]    <= y_next[k+1];
                z_reg[k+1]    <= z_next[k+1];
                flip_reg[k+1] <= flip_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // undo the fold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg      <= flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
            sin_reg      <= flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
            out_side_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = out_side_reg;

    `PRA_ASSERT(a_cos_unit, out_valid_reg |-> (cos_reg <= CS_LIM) && (cos_reg >= -CS_LIM), "cordic cos out of range")
    `PRA_ASSERT(a_sin_unit, out_valid_reg |-> (sin_reg <= CS_LIM) && (sin_reg >= -CS_LIM), "cordic sin out of range")
    `PRA_ASSERT(a_stall_hold, out_valid_reg && !en |=> $stable(cos_reg) && $stable(sin_reg), "cordic output moved while stalled")

endmodule

// ===== hdl/point_rotate_about_pivot.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_pivot
// Rotates a Q16.16 point about a pivot by a binary angle in a y-down frame,
// saturating the result. One word in and one word out per clock when the
// output side keeps up. The pipeline has one stage per cordic iteration
// plus a fold stage and a sign-fix stage in the cordic, followed by three
// multiply and rounding stages and the output register. The output register
// has a skid word behind it, which lets a new word in during the first cycle
// of an output stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_rotate_about_pivot #(
    parameter int CORDIC_STEPS = pra_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pra_pkg::pra_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pra_pkg::pra_out_t m_data
);

    localparam int W      = pra_pkg::COORD_W;
    localparam int CW     = pra_pkg::CS_W;
    localparam int DW     = W + 1;                 // point minus pivot
    localparam int LO_W   = DW / 2;
    localparam int HI_W   = DW - LO_W;
    localparam int PH_W   = HI_W + CW;
    localparam int PL_W   = LO_W + 1 + CW;
    localparam int SH_W   = PH_W + 1;
    localparam int SL_W   = PL_W + 2;
    localparam int TW     = W + 36;
    localparam int QW     = W + 3;
    localparam int SW     = QW + 1;
    localparam int SIDE_W = 2 * DW + 2 * W;

    localparam logic signed [SL_W-1:0] ROUND_HALF =
        signed'(SL_W'(1) << (pra_pkg::FRAC_W - 1));
    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    // input side
    logic                     pipe_en;
    logic signed [DW-1:0]     dx_in;
    logic signed [DW-1:0]     dy_in;
    logic        [SIDE_W-1:0] side_in;

    // cordic outputs
    logic                     c_valid;
    logic signed [CW-1:0]     c_cos;
    logic signed [CW-1:0]     c_sin;
    logic        [SIDE_W-1:0] c_side;
    logic signed [DW-1:0]     c_dx;
    logic signed [DW-1:0]     c_dy;
    logic signed [W-1:0]      c_ox;
    logic signed [W-1:0]      c_oy;

    // product stage
    logic                   pv_reg;
    logic signed [PH_W-1:0] xch_reg, ysh_reg, ych_reg, xsh_reg;
    logic signed [PL_W-1:0] xcl_reg, ysl_reg, ycl_reg, xsl_reg;
    logic signed [W-1:0]    pox_reg, poy_reg;

    // partial sum stage
    logic                   sv_reg;
    logic signed [SH_W-1:0] hx_reg, hy_reg;
    logic signed [SL_W-1:0] lx_reg, ly_reg;
    logic signed [W-1:0]    sox_reg, soy_reg;
    logic signed [SH_W-1:0] hx_next, hy_next;
    logic signed [SL_W-1:0] lx_next, ly_next;

    // rounded term stage
    logic                   qv_reg;
    logic signed [QW-1:0]   qx_reg, qy_reg;
    logic signed [W-1:0]    qox_reg, qoy_reg;
    logic signed [TW-1:0]   tx_next, ty_next;

    // clamp and output
    logic signed [SW-1:0]   sum_x, sum_y;
    logic                   fit_x, fit_y;
    logic                   fin_valid;
    pra_pkg::pra_out_t      fin_data;

    logic                   m_valid_reg;
    pra_pkg::pra_out_t      m_data_reg;
    logic                   skid_valid_reg;
    pra_pkg::pra_out_t      skid_data_reg;

    // the whole pipeline moves unless the skid word is occupied
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_comb begin
        dx_in   = DW'(s_data.point_x) - DW'(s_data.pivot_x);
        dy_in   = DW'(s_data.point_y) - DW'(s_data.pivot_y);
        side_in = {dx_in, dy_in, s_data.pivot_x, s_data.pivot_y};
    end

    pra_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_angle  (s_data.turn_angle),
        .in_side   (side_in),
        .out_valid (c_valid),
        .out_cos   (c_cos),
        .out_sin   (c_sin),
        .out_side  (c_side)
    );

    assign c_dx = signed'(c_side[SIDE_W-1 -: DW]);
    assign c_dy = signed'(c_side[SIDE_W-DW-1 -: DW]);
    assign c_ox = signed'(c_side[2*W-1 -: W]);
    assign c_oy = signed'(c_side[W-1:0]);

    // offsets split into a signed high part and an unsigned low part
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (pipe_en) begin
            pv_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            xch_reg <= signed'(c_dx[DW-1:LO_W]) * c_cos;
            xcl_reg <= signed'({1'b0, c_dx[LO_W-1:0]}) * c_cos;
            ysh_reg <= signed'(c_dy[DW-1:LO_W]) * c_sin;
            ysl_reg <= signed'({1'b0, c_dy[LO_W-1:0]}) * c_sin;
            ych_reg <= signed'(c_dy[DW-1:LO_W]) * c_cos;
            ycl_reg <= signed'({1'b0, c_dy[LO_W-1:0]}) * c_cos;
            xsh_reg <= signed'(c_dx[DW-1:LO_W]) * c_sin;
            xsl_reg <= signed'({1'b0, c_dx[LO_W-1:0]}) * c_sin;
            pox_reg <= c_ox;
            poy_reg <= c_oy;
        end
    end

    // x term is dx*cos + dy*sin, y term is dy*cos - dx*sin
    always_comb begin
        hx_next = SH_W'(xch_reg) + SH_W'(ysh_reg);
        hy_next = SH_W'(ych_reg) - SH_W'(xsh_reg);
        lx_next = SL_W'(xcl_reg) + SL_W'(ysl_reg) + ROUND_HALF;
        ly_next = SL_W'(ycl_reg) - SL_W'(xsl_reg) + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
        end else if (pipe_en) begin
            sv_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hx_reg  <= hx_next;
            hy_reg  <= hy_next;
            lx_reg  <= lx_next;
            ly_reg  <= ly_next;
            sox_reg <= pox_reg;
            soy_reg <= poy_reg;
        end
    end

    // join the halves, then floor by 2^30
    always_comb begin
        tx_next = (TW'(hx_reg) <<< LO_W) + TW'(lx_reg);
        ty_next = (TW'(hy_reg) <<< LO_W) + TW'(ly_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg <= 1'b0;
        end else if (pipe_en) begin
            qv_reg <= sv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            qx_reg  <= signed'(tx_next[pra_pkg::FRAC_W +: QW]);
            qy_reg  <= signed'(ty_next[pra_pkg::FRAC_W +: QW]);
            qox_reg <= sox_reg;
            qoy_reg <= soy_reg;
        end
    end

    // add pivot back and clamp to the coordinate range
    always_comb begin
        sum_x = SW'(qx_reg) + SW'(qox_reg);
        sum_y = SW'(qy_reg) + SW'(qoy_reg);
        fit_x = (&sum_x[SW-1:W-1]) || !(|sum_x[SW-1:W-1]);
        fit_y = (&sum_y[SW-1:W-1]) || !(|sum_y[SW-1:W-1]);
        fin_data.rotated_x = fit_x ? sum_x[W-1:0] : (sum_x[SW-1] ? COORD_MIN : COORD_MAX);
        fin_data.rotated_y = fit_y ? sum_y[W-1:0] : (sum_y[SW-1] ? COORD_MIN : COORD_MAX);
        fin_data.saturated = !fit_x || !fit_y;
        fin_valid          = qv_reg && pipe_en;
    end

    // output register with one skid word behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= fin_valid;
            end
        end else if (fin_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : fin_data;
        end else if (fin_valid) begin
            skid_data_reg <= fin_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PRA_ASSERT(a_skid_behind_out, skid_valid_reg |-> m_valid_reg, "skid word held with empty output register")
    `PRA_ASSERT(a_skid_on_stall, $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready), "skid filled without an output stall")
    `PRA_ASSERT(a_sat_at_bound, m_valid_reg && m_data_reg.saturated |-> (m_data_reg.rotated_x == COORD_MAX) || (m_data_reg.rotated_x == COORD_MIN) || (m_data_reg.rotated_y == COORD_MAX) || (m_data_reg.rotated_y == COORD_MIN), "saturated flag without a clamped coordinate")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point rotation pipeline. Points, pivots and
// angles go in over a valid/ready channel with random gaps. Each accepted word
// is rotated by an independent fixed-point cordic predictor, and every output
// word is compared field by field, in order, against that prediction. The
// output side stalls at random and once holds off long enough to back up the
// whole pipeline.
// ----------------------------------------------------------------------------
module tb;

    localparam int STEPS        = pra_pkg::CORDIC_STEPS_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TAIL_ITEMS   = 150;   // no idling on either side at the end
    localparam int CALM_SPAN    = 150;
    localparam int HOLD_AFTER   = 400;   // words received before the long hold
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 2 * (STEPS + 6);
    localparam int LIMIT        = 400000;

    localparam longint COORD_MAX = (longint'(1) <<< (pra_pkg::COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    localparam logic [pra_pkg::COORD_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [pra_pkg::COORD_W-1:0] CMAX      = 32'h7FFF_FFFF;
    localparam logic [pra_pkg::COORD_W-1:0] CMIN      = 32'h8000_0000;
    localparam logic [pra_pkg::ANGLE_W-1:0] QUARTER   = 32'h4000_0000;
    localparam logic [pra_pkg::ANGLE_W-1:0] HALF      = 32'h8000_0000;
    localparam logic [pra_pkg::ANGLE_W-1:0] NEG_QUART = 32'hC000_0000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pra_pkg::pra_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pra_pkg::pra_out_t m_data;

    pra_pkg::pra_in_t  pending_points[$];
    pra_pkg::pra_out_t expected_rotations[$];

    int total_items   = 0;
    int n_offered     = 0;
    int n_accepted    = 0;
    int n_checked     = 0;
    int n_clamped     = 0;
    int n_held_back   = 0;
    int n_errors      = 0;
    int cycle_count   = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;

    point_rotate_about_pivot #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // round((a*c1 + b*c2) / 2^30), half up, formed exactly
    function automatic longint rounded_mix(longint a, longint c1, longint b, longint c2);
        logic signed [95:0] wa, wb, w1, w2, acc;
        wa  = a;
        wb  = b;
        w1  = c1;
        w2  = c2;
        acc = wa * w1 + wb * w2 + (96'sd1 <<< (pra_pkg::FRAC_W - 1));
        acc = acc >>> pra_pkg::FRAC_W;
        return acc[63:0];
    endfunction

    function automatic longint clamp_coord(longint v, ref bit hit);
        if (v > COORD_MAX) begin
            hit = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            hit = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic pra_pkg::pra_out_t rotated_point(pra_pkg::pra_in_t w);
        logic [pra_pkg::ANGLE_W-1:0] ang;
        logic [pra_pkg::ANGLE_W-1:0] probe;
        bit                          flip;
        bit                          hit;
        longint                      z, cx, sy, xs, ys, dx, dy, rx, ry;
        pra_pkg::pra_out_t           r;
        ang   = w.turn_angle;
        probe = ang + QUARTER;
        flip  = probe[pra_pkg::ANGLE_W-1];
        // fold into a quarter turn either way, fix the sign afterwards
        if (flip)
            ang = ang + HALF;
        z   = $signed(ang);
        cx  = pra_pkg::CORDIC_GAIN;
        sy  = 0;
        hit = 1'b0;
        for (int i = 0; i < STEPS && i < pra_pkg::MAX_STEPS; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (z >= 0) begin
                cx = cx - ys;
                sy = sy + xs;
                z  = z - pra_pkg::ARC_TABLE[i];
            end else begin
                cx = cx + ys;
                sy = sy - xs;
                z  = z + pra_pkg::ARC_TABLE[i];
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        // offsets are one bit wider than the coordinates, never wrapped
        dx = longint'(w.point_x) - longint'(w.pivot_x);
        dy = longint'(w.point_y) - longint'(w.pivot_y);
        rx = clamp_coord(rounded_mix(dx, cx, dy, sy) + longint'(w.pivot_x), hit);
        ry = clamp_coord(rounded_mix(dy, cx, dx, -sy) + longint'(w.pivot_y), hit);
        r.rotated_x = rx[pra_pkg::COORD_W-1:0];
        r.rotated_y = ry[pra_pkg::COORD_W-1:0];
        r.saturated = hit;
        return r;
    endfunction

    function automatic bit idle_allowed(int n);
        return (n < total_items - TAIL_ITEMS) && ((n / CALM_SPAN) % 4 != 3);
    endfunction

    function automatic logic [pra_pkg::COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return CMAX;
                    1:       return CMIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [pra_pkg::ANGLE_W-1:0] random_angle();
        // near the octant boundaries now and then, where the fold turns over
        if ($urandom_range(0, 3) == 0)
            return (32'($urandom_range(0, 7)) << 29) + $urandom_range(0, 8) - 32'd4;
        return $urandom();
    endfunction

    task automatic queue_point(logic [pra_pkg::COORD_W-1:0] px,
                               logic [pra_pkg::COORD_W-1:0] py,
                               logic [pra_pkg::COORD_W-1:0] ox,
                               logic [pra_pkg::COORD_W-1:0] oy,
                               logic [pra_pkg::ANGLE_W-1:0] ang);
        pra_pkg::pra_in_t w;
        w.point_x    = px;
        w.point_y    = py;
        w.pivot_x    = ox;
        w.pivot_y    = oy;
        w.turn_angle = ang;
        pending_points.push_back(w);
    endtask

    // stimulus word driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rotations.push_back(rotated_point(s_data));
                n_accepted++;
            end else if (s_valid) begin
                n_held_back++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_points.pop_front();
                    n_offered++;
                    if (idle_allowed(n_offered) && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result word monitor
    always @(posedge aclk) begin : result_monitor
        pra_pkg::pra_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rotations.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d sat=%0d", $time,
                             m_data.rotated_x, m_data.rotated_y, m_data.saturated);
                    n_errors++;
                end else begin
                    want = expected_rotations.pop_front();
                    if (m_data.rotated_x !== want.rotated_x) begin
                        $display("%0t: rotated_x expected %0d actual %0d", $time,
                                 want.rotated_x, m_data.rotated_x);
                        n_errors++;
                    end
                    if (m_data.rotated_y !== want.rotated_y) begin
                        $display("%0t: rotated_y expected %0d actual %0d", $time,
                                 want.rotated_y, m_data.rotated_y);
                        n_errors++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %0d actual %0d", $time,
                                 want.saturated, m_data.saturated);
                        n_errors++;
                    end
                end
                n_checked++;
                if (m_data.saturated === 1'b1)
                    n_clamped++;
                // one long hold so the pipeline fills and pushes back
                if (n_checked == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_allowed(n_checked) && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     expected_rotations.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [pra_pkg::COORD_W-1:0] ox, oy;

        // origin, unit vector round the special angles, saturating corners
        queue_point('0, '0, '0, '0, '0);
        queue_point(ONE_Q16, '0, '0, '0, '0);
        queue_point(ONE_Q16, '0, '0, '0, QUARTER);
        queue_point(ONE_Q16, '0, '0, '0, NEG_QUART);
        queue_point(ONE_Q16, '0, '0, '0, HALF);
        queue_point(ONE_Q16, '0, '0, '0, 32'h2000_0000);
        queue_point(ONE_Q16, '0, '0, '0, 32'h3FFF_FFFF);
        queue_point(ONE_Q16, '0, '0, '0, 32'hBFFF_FFFF);
        queue_point(ONE_Q16, '0, '0, '0, 32'h7FFF_FFFF);
        queue_point(ONE_Q16, '0, '0, '0, 32'hFFFF_FFFF);
        queue_point(CMAX, CMAX, CMIN, CMIN, '0);
        queue_point(CMAX, CMAX, CMIN, CMIN, HALF);
        queue_point(CMIN, CMIN, CMAX, CMAX, QUARTER);
        queue_point(CMAX, CMIN, CMIN, CMAX, NEG_QUART);
        queue_point(CMAX, CMAX, CMAX, CMAX, 32'h1234_5678);
        queue_point(CMIN, CMIN, CMIN, CMIN, HALF);
        queue_point(CMAX, CMIN, '0, '0, 32'h2000_0000);
        queue_point(32'h0012_3456, 32'hFFED_CBAA, 32'h0012_3456, 32'hFFED_CBAA,
                    32'h5555_5555);
        queue_point(32'h0003_8000, 32'hFFFD_C000, ONE_Q16, ONE_Q16, QUARTER);
        queue_point('1, '1, 32'h0000_0001, 32'h0000_0001, 32'hAAAA_AAAA);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            ox = random_coord();
            oy = random_coord();
            // half the points close to their pivot, as in a drawing stream
            if ($urandom_range(0, 1) == 0)
                queue_point(ox + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                            oy + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                            ox, oy, random_angle());
            else
                queue_point(random_coord(), random_coord(), ox, oy, random_angle());
        end
        total_items = pending_points.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < total_items)
            @(posedge aclk);
        while (expected_rotations.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("rotated %0d points about their pivots, %0d with a clamped coordinate",
                 n_checked, n_clamped);
        $display("input held back for %0d cycles by output stalls", n_held_back);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
